/* hdl/ipcp_pkg.sv */
// Package: shared types, codes and option decode for the IPCP option negotiator.
`timescale 1ns / 1ps

package ipcp_pkg;

	localparam int NUM_OPTS  = 5;
	localparam int SLOT_W    = 3;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 3;

	// item modes
	localparam logic [2:0] MODE_REQ     = 3'd0;
	localparam logic [2:0] MODE_EMPTY   = 3'd1;
	localparam logic [2:0] MODE_REJOPT  = 3'd2;
	localparam logic [2:0] MODE_ACKRX   = 3'd3;
	localparam logic [2:0] MODE_RESTART = 3'd4;

	// verdicts; ack, nak and reject double as response codes
	localparam logic [1:0] VERDICT_ACK  = 2'd0;
	localparam logic [1:0] VERDICT_NAK  = 2'd1;
	localparam logic [1:0] VERDICT_REJ  = 2'd2;
	localparam logic [1:0] VERDICT_NONE = 2'd3;

	// option types
	localparam logic [7:0] OPT_ADDR  = 8'd3;
	localparam logic [7:0] OPT_DNS1  = 8'd129;
	localparam logic [7:0] OPT_NBNS1 = 8'd130;
	localparam logic [7:0] OPT_DNS2  = 8'd131;
	localparam logic [7:0] OPT_NBNS2 = 8'd132;

	typedef struct packed {
		logic [2:0]        mode;
		logic [7:0]        option_type;
		logic [ADDR_W-1:0] option_value;
		logic              first_option;
		logic              last_option;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          verdict;
		logic [ADDR_W-1:0]   reply_value;
		logic [1:0]          response_code;
		logic [NUM_OPTS-1:0] request_mask;
		logic                ack_sent;
		logic                ack_received;
		logic                link_up;
	} out_item_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] idx;
	} slot_t;

	// write request into the address store
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] data;
	} addr_wr_t;

	// where an address entry currently takes its value from
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_CFG  = 2'd1,
		SRC_MEM  = 2'd2
	} addr_src_t;

	function automatic slot_t type_slot(input logic [7:0] t);
		slot_t s;
		s.ok  = 1'b1;
		s.idx = '0;
		case (t)
			OPT_ADDR:  s.idx = 3'd0;
			OPT_DNS1:  s.idx = 3'd1;
			OPT_NBNS1: s.idx = 3'd2;
			OPT_DNS2:  s.idx = 3'd3;
			OPT_NBNS2: s.idx = 3'd4;
			default:   s.ok  = 1'b0;
		endcase
		return s;
	endfunction

	// slot order vs register order: slots 2 and 3 swap; the map is its own inverse
	function automatic logic [SLOT_W-1:0] slot_reg_map(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		case (s)
			3'd2:    r = 3'd3;
			3'd3:    r = 3'd2;
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

/* hdl/ipcp_cfg_regs.sv */
// Configuration registers with one shared read port.
`timescale 1ns / 1ps

module ipcp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [ipcp_pkg::CFG_IDX_W-1:0]     index,
	input  logic [ipcp_pkg::ADDR_W-1:0]        wdata,
	input  logic [ipcp_pkg::SLOT_W-1:0]        rd_reg,
	output logic [ipcp_pkg::ADDR_W-1:0]        rd_data
);

	logic [ipcp_pkg::ADDR_W-1:0] regs_q [ipcp_pkg::NUM_OPTS];
	logic                        idx_ok;

	assign idx_ok = 32'(index) < ipcp_pkg::NUM_OPTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (we && idx_ok) begin
			regs_q[index[ipcp_pkg::SLOT_W-1:0]] <= wdata;
		end
	end

	always_comb begin
		rd_data = '0;
		if (32'(rd_reg) < ipcp_pkg::NUM_OPTS) begin
			rd_data = regs_q[rd_reg];
		end
	end

endmodule

/* hdl/ipcp_addr_store.sv */
// Current address memory: sync read, source tags, write-to-read forwarding.
`timescale 1ns / 1ps

module ipcp_addr_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [ipcp_pkg::SLOT_W-1:0]   rd_slot,
	input  ipcp_pkg::addr_wr_t            wr,
	input  logic                          restart,
	input  logic                          cvt_en,
	input  logic [ipcp_pkg::SLOT_W-1:0]   cvt_slot,
	input  logic [ipcp_pkg::ADDR_W-1:0]   cfg_data,
	output logic [ipcp_pkg::ADDR_W-1:0]   cur
);

	logic [ipcp_pkg::ADDR_W-1:0] mem [ipcp_pkg::NUM_OPTS];
	logic [ipcp_pkg::ADDR_W-1:0] rd_q;
	logic [ipcp_pkg::ADDR_W-1:0] fwd_q;
	logic                        fwd_hit_q;
	logic [ipcp_pkg::SLOT_W-1:0] slot_q;
	ipcp_pkg::addr_src_t         src_q [ipcp_pkg::NUM_OPTS];
	ipcp_pkg::addr_wr_t          port;
	ipcp_pkg::addr_src_t         cur_src;

	// config-time conversion freezes a restart snapshot before the register changes
	always_comb begin
		port = wr;
		if (cvt_en && src_q[cvt_slot] == ipcp_pkg::SRC_CFG) begin
			port.en   = 1'b1;
			port.slot = cvt_slot;
			port.data = cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (port.en) begin
			mem[port.slot] <= port.data;
		end
		if (rd_en) begin
			rd_q   <= mem[rd_slot];
			slot_q <= rd_slot;
			fwd_q  <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
			for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++) begin
				src_q[i] <= ipcp_pkg::SRC_ZERO;
			end
		end else begin
			if (rd_en) begin
				fwd_hit_q <= wr.en && (wr.slot == rd_slot);
			end
			if (restart) begin
				for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++) begin
					src_q[i] <= ipcp_pkg::SRC_CFG;
				end
			end else if (port.en) begin
				src_q[port.slot] <= ipcp_pkg::SRC_MEM;
			end
		end
	end

	assign cur_src = (32'(slot_q) < ipcp_pkg::NUM_OPTS) ? src_q[slot_q] : ipcp_pkg::SRC_ZERO;

	always_comb begin
		case (cur_src)
			ipcp_pkg::SRC_ZERO: cur = '0;
			ipcp_pkg::SRC_CFG:  cur = cfg_data;
			ipcp_pkg::SRC_MEM:  cur = fwd_hit_q ? fwd_q : rd_q;
			default:            cur = '0;
		endcase
	end

endmodule

/* hdl/ipcp_option_negotiator.sv */
// Top level: IPCP option negotiator, one option request per item.
//
//  channel | signals                          | moves
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | one option or control request
//  out     | out_valid, out_ready, out_data   | verdict and negotiation status
//  cfg     | cfg_we, cfg_index, cfg_wdata     | configured address registers
//
// The accepting edge reads the address memory; the judge stage then judges and
// writes back into the output register. One request per cycle is taken unless
// the output stalls; a back-to-back request to the same option gets the written
// address by forwarding. Reset clears the ack flags and tags and sets the
// request flags; address entries read as zero until written or restarted.
// A stalled output holds the judge stage, and in_ready drops only then.
`timescale 1ns / 1ps

module ipcp_option_negotiator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ipcp_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ipcp_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [ipcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipcp_pkg::ADDR_W-1:0]        cfg_wdata
);

	logic                        valid_s1;
	ipcp_pkg::in_item_t          item_s1;
	ipcp_pkg::slot_t             slot_s1;
	ipcp_pkg::slot_t             in_slot;
	logic                        s1_fire;
	logic                        in_fire;

	logic [1:0]                  sev_q;
	logic [ipcp_pkg::NUM_OPTS-1:0] req_q;
	logic                        sent_q;
	logic                        rcv_q;
	ipcp_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic [ipcp_pkg::ADDR_W-1:0] cur;
	logic [ipcp_pkg::ADDR_W-1:0] cfg_rd;
	logic [ipcp_pkg::SLOT_W-1:0] cfg_rd_reg;
	logic                        configured;
	logic                        cvt_en;
	ipcp_pkg::addr_wr_t          wr;
	logic                        restart;

	logic [1:0]                  verdict;
	logic [ipcp_pkg::ADDR_W-1:0] reply;
	logic [1:0]                  sev_d;
	logic [ipcp_pkg::NUM_OPTS-1:0] req_d;
	logic                        sent_d;
	logic                        rcv_d;

	assign in_slot  = ipcp_pkg::type_slot(in_data.option_type);
	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	// shared config read port: the user must write config only while the pipe is empty; the block does not enforce it
	assign cvt_en     = cfg_we && (32'(cfg_index) < ipcp_pkg::NUM_OPTS);
	assign cfg_rd_reg = cfg_we ? cfg_index[ipcp_pkg::SLOT_W-1:0]
	                           : ipcp_pkg::slot_reg_map(slot_s1.idx);
	assign configured = cfg_rd != '0;

	ipcp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (cfg_we),
		.index   (cfg_index),
		.wdata   (cfg_wdata),
		.rd_reg  (cfg_rd_reg),
		.rd_data (cfg_rd)
	);

	ipcp_addr_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_slot  (in_slot.idx),
		.wr       (wr),
		.restart  (restart),
		.cvt_en   (cvt_en),
		.cvt_slot (ipcp_pkg::slot_reg_map(cfg_index[ipcp_pkg::SLOT_W-1:0])),
		.cfg_data (cfg_rd),
		.cur      (cur)
	);

	always_comb begin
		verdict = ipcp_pkg::VERDICT_NONE;
		reply   = '0;
		sev_d   = sev_q;
		req_d   = req_q;
		sent_d  = sent_q;
		rcv_d   = rcv_q;
		wr.en   = 1'b0;
		wr.slot = slot_s1.idx;
		wr.data = item_s1.option_value;
		restart = 1'b0;
		case (item_s1.mode)
			ipcp_pkg::MODE_REQ: begin
				if (item_s1.first_option) begin
					sev_d = ipcp_pkg::VERDICT_ACK;
				end
				if (!slot_s1.ok) begin
					verdict = ipcp_pkg::VERDICT_REJ;
					reply   = item_s1.option_value;
				end else if (item_s1.option_value == '0) begin
					verdict = configured ? ipcp_pkg::VERDICT_NAK : ipcp_pkg::VERDICT_REJ;
					reply   = configured ? cur : item_s1.option_value;
				end else if (cur == item_s1.option_value) begin
					verdict = ipcp_pkg::VERDICT_ACK;
					reply   = item_s1.option_value;
				end else if (configured) begin
					verdict = ipcp_pkg::VERDICT_NAK;
					reply   = cur;
				end else begin
					// unconfigured: adopt the peer's address
					wr.en   = s1_fire;
					verdict = ipcp_pkg::VERDICT_ACK;
					reply   = item_s1.option_value;
				end
				if (verdict > sev_d) begin
					sev_d = verdict;
				end
				if (item_s1.last_option && sev_d == ipcp_pkg::VERDICT_ACK) begin
					sent_d = 1'b1;
				end
			end
			ipcp_pkg::MODE_EMPTY: begin
				sev_d  = ipcp_pkg::VERDICT_ACK;
				sent_d = 1'b1;
			end
			ipcp_pkg::MODE_REJOPT: begin
				if (slot_s1.ok) begin
					req_d[slot_s1.idx] = 1'b0;
				end
			end
			ipcp_pkg::MODE_ACKRX: begin
				rcv_d = 1'b1;
			end
			ipcp_pkg::MODE_RESTART: begin
				sent_d  = 1'b0;
				rcv_d   = 1'b0;
				restart = s1_fire;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
			slot_s1 <= in_slot;
		end
		if (s1_fire) begin
			out_q.verdict       <= verdict;
			out_q.reply_value   <= reply;
			out_q.response_code <= sev_d;
			out_q.request_mask  <= req_d;
			out_q.ack_sent      <= sent_d;
			out_q.ack_received  <= rcv_d;
			out_q.link_up       <= sent_d & rcv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			sev_q       <= ipcp_pkg::VERDICT_ACK;
			req_q       <= '1;
			sent_q      <= 1'b0;
			rcv_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				sev_q       <= sev_d;
				req_q       <= req_d;
				sent_q      <= sent_d;
				rcv_q       <= rcv_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.response_code != ipcp_pkg::VERDICT_NONE))
		else $error("response code out of range");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.mode == ipcp_pkg::MODE_RESTART) |=> (!sent_q && !rcv_q))
		else $error("restart left an ack flag set");

	a_mask_falls_only: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((req_q & ~$past(req_q)) == '0))
		else $error("request flag set again");

endmodule

/* tb/ipcp_option_negotiator_tb.sv */
// Testbench for ipcp_option_negotiator: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps

module ipcp_option_negotiator_tb;

	// register indexes of the configuration port
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] REG_REMOTE = 3'd0;
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] REG_DNS1   = 3'd1;
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] REG_DNS2   = 3'd2;
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] REG_NBNS1  = 3'd3;
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] REG_NBNS2  = 3'd4;
	localparam int NUM_REGS = 5;

	localparam logic [7:0] KNOWN_TYPES [ipcp_pkg::NUM_OPTS] = '{ipcp_pkg::OPT_ADDR,
		ipcp_pkg::OPT_DNS1, ipcp_pkg::OPT_NBNS1, ipcp_pkg::OPT_DNS2, ipcp_pkg::OPT_NBNS2};
	// mask slot order differs from register order
	localparam logic [ipcp_pkg::CFG_IDX_W-1:0] SLOT_REG [ipcp_pkg::NUM_OPTS] = '{REG_REMOTE,
		REG_DNS1, REG_NBNS1, REG_DNS2, REG_NBNS2};

	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_ITEMS     = 125;
	localparam int HOLD_AT_RESULT  = 400;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 10;
	localparam longint RUN_LIMIT_NS = 2000000;

	typedef struct {
		ipcp_pkg::in_item_t  req;
		bit                  typed;
		ipcp_pkg::out_item_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	ipcp_pkg::in_item_t   in_data;
	logic                 out_valid;
	logic                 out_ready;
	ipcp_pkg::out_item_t  out_data;
	logic                 cfg_we;
	logic [ipcp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ipcp_pkg::ADDR_W-1:0]    cfg_wdata;

	// predictor state
	logic [ipcp_pkg::ADDR_W-1:0]   cfg_shadow [NUM_REGS];
	logic [ipcp_pkg::ADDR_W-1:0]   addr_shadow [ipcp_pkg::NUM_OPTS];
	logic [1:0]                    code_shadow;
	logic [ipcp_pkg::NUM_OPTS-1:0] mask_shadow;
	logic                          sent_shadow;
	logic                          rcvd_shadow;

	ipcp_pkg::out_item_t expected_q [$];
	dir_row_t  dir_rows [$];
	int  mismatches;
	int  requests_sent;
	int  results_seen;
	int  reg_writes;
	bit  sender_calm;
	bit  receiver_calm;

	ipcp_option_negotiator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int slot_for(input logic [7:0] t);
		int s;
		s = -1;
		for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++)
			if (KNOWN_TYPES[i] == t)
				s = i;
		return s;
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < NUM_REGS; i++)
			cfg_shadow[i] = '0;
		for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++)
			addr_shadow[i] = '0;
		code_shadow = ipcp_pkg::VERDICT_ACK;
		mask_shadow = '1;
		sent_shadow = 1'b0;
		rcvd_shadow = 1'b0;
	endfunction

	// verdict and status for one request; updates the negotiation state
	function automatic ipcp_pkg::out_item_t negotiate(input ipcp_pkg::in_item_t r);
		ipcp_pkg::out_item_t o;
		int slot;
		logic [1:0] v;
		logic [ipcp_pkg::ADDR_W-1:0] reply;
		logic configured;
		slot = slot_for(r.option_type);
		v = ipcp_pkg::VERDICT_NONE;
		reply = '0;
		case (r.mode)
			ipcp_pkg::MODE_REQ: begin
				if (r.first_option)
					code_shadow = ipcp_pkg::VERDICT_ACK;
				if (slot < 0) begin
					v = ipcp_pkg::VERDICT_REJ;
					reply = r.option_value;
				end else begin
					configured = cfg_shadow[SLOT_REG[slot]] != '0;
					if (r.option_value == '0) begin
						v = configured ? ipcp_pkg::VERDICT_NAK : ipcp_pkg::VERDICT_REJ;
						reply = configured ? addr_shadow[slot] : '0;
					end else if (addr_shadow[slot] == r.option_value) begin
						v = ipcp_pkg::VERDICT_ACK;
						reply = r.option_value;
					end else if (configured) begin
						v = ipcp_pkg::VERDICT_NAK;
						reply = addr_shadow[slot];
					end else begin
						// peer picks the address when we have none configured
						addr_shadow[slot] = r.option_value;
						v = ipcp_pkg::VERDICT_ACK;
						reply = r.option_value;
					end
				end
				if (v > code_shadow)
					code_shadow = v;
				if (r.last_option && code_shadow == ipcp_pkg::VERDICT_ACK)
					sent_shadow = 1'b1;
			end
			ipcp_pkg::MODE_EMPTY: begin
				code_shadow = ipcp_pkg::VERDICT_ACK;
				sent_shadow = 1'b1;
			end
			ipcp_pkg::MODE_REJOPT: begin
				if (slot >= 0)
					mask_shadow[slot] = 1'b0;
			end
			ipcp_pkg::MODE_ACKRX: begin
				rcvd_shadow = 1'b1;
			end
			ipcp_pkg::MODE_RESTART: begin
				sent_shadow = 1'b0;
				rcvd_shadow = 1'b0;
				for (int i = 0; i < ipcp_pkg::NUM_OPTS; i++)
					addr_shadow[i] = cfg_shadow[SLOT_REG[i]];
			end
			default: ;
		endcase
		o.verdict = v;
		o.reply_value = reply;
		o.response_code = code_shadow;
		o.request_mask = mask_shadow;
		o.ack_sent = sent_shadow;
		o.ack_received = rcvd_shadow;
		o.link_up = sent_shadow & rcvd_shadow;
		return o;
	endfunction

	task automatic note_mismatch(input string what, input logic [ipcp_pkg::ADDR_W-1:0] got,
			input logic [ipcp_pkg::ADDR_W-1:0] want);
		mismatches++;
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	task automatic compare_result(input ipcp_pkg::out_item_t got,
			input ipcp_pkg::out_item_t want);
		if (got.verdict !== want.verdict)
			note_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
		if (got.reply_value !== want.reply_value)
			note_mismatch("reply_value", got.reply_value, want.reply_value);
		if (got.response_code !== want.response_code)
			note_mismatch("response_code", 32'(got.response_code), 32'(want.response_code));
		if (got.request_mask !== want.request_mask)
			note_mismatch("request_mask", 32'(got.request_mask), 32'(want.request_mask));
		if (got.ack_sent !== want.ack_sent)
			note_mismatch("ack_sent", 32'(got.ack_sent), 32'(want.ack_sent));
		if (got.ack_received !== want.ack_received)
			note_mismatch("ack_received", 32'(got.ack_received), 32'(want.ack_received));
		if (got.link_up !== want.link_up)
			note_mismatch("link_up", 32'(got.link_up), 32'(want.link_up));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0)
				note_mismatch("unexpected result", out_data.reply_value, '0);
			else
				compare_result(out_data, expected_q.pop_front());
		end
	end

	function automatic ipcp_pkg::in_item_t mk_req(input logic [2:0] m, input logic [7:0] t,
			input logic [ipcp_pkg::ADDR_W-1:0] v, input logic f, input logic l);
		ipcp_pkg::in_item_t r;
		r.mode = m;
		r.option_type = t;
		r.option_value = v;
		r.first_option = f;
		r.last_option = l;
		return r;
	endfunction

	function automatic ipcp_pkg::out_item_t mk_res(input logic [1:0] v,
			input logic [ipcp_pkg::ADDR_W-1:0] rv, input logic [1:0] c,
			input logic [ipcp_pkg::NUM_OPTS-1:0] m, input logic s, input logic a);
		ipcp_pkg::out_item_t o;
		o.verdict = v;
		o.reply_value = rv;
		o.response_code = c;
		o.request_mask = m;
		o.ack_sent = s;
		o.ack_received = a;
		o.link_up = s & a;
		return o;
	endfunction

	function automatic void add_row(input ipcp_pkg::in_item_t r, input bit typed,
			input ipcp_pkg::out_item_t w);
		dir_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = w;
		dir_rows.push_back(row);
	endfunction

	task automatic send_req(input ipcp_pkg::in_item_t r, input bit typed,
			input ipcp_pkg::out_item_t want);
		int gap;
		ipcp_pkg::out_item_t pred;
		gap = sender_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = negotiate(r);
		expected_q.push_back(typed ? want : pred);
		requests_sent++;
	endtask

	task automatic send_plain(input ipcp_pkg::in_item_t r);
		send_req(r, 1'b0, '0);
	endtask

	// registers change only with the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// cfg_we stays high over a run of writes; the caller drops it afterwards
	task automatic write_reg(input logic [ipcp_pkg::CFG_IDX_W-1:0] idx,
			input logic [ipcp_pkg::ADDR_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx < NUM_REGS)
			cfg_shadow[idx] = val;
		reg_writes++;
	endtask

	function automatic logic [ipcp_pkg::ADDR_W-1:0] pick_addr(input int phase_kind,
			input int idx);
		case (phase_kind)
			0: return '0;
			1: return '1;
			2: return ($urandom_range(0, 2) == 0) ? '0 : $urandom();
			3: return (idx % 2 == 0) ? 32'h0000_0001 : 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// option value chosen to hit equality with state often
	function automatic logic [ipcp_pkg::ADDR_W-1:0] pick_value(input int slot);
		int k;
		k = $urandom_range(0, 5);
		if (slot < 0)
			return (k == 0) ? '0 : $urandom();
		case (k)
			0: return '0;
			1, 2: return addr_shadow[slot];
			3: return cfg_shadow[SLOT_REG[slot]];
			4: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_packet();
		int n;
		int slot;
		logic [7:0] t;
		logic f;
		logic l;
		bit broken;
		n = $urandom_range(1, 5);
		broken = $urandom_range(0, 9) == 0;
		for (int k = 0; k < n; k++) begin
			t = ($urandom_range(0, 9) != 0)
				? KNOWN_TYPES[$urandom_range(0, ipcp_pkg::NUM_OPTS - 1)]
				: 8'($urandom());
			slot = slot_for(t);
			f = (k == 0);
			l = (k == n - 1);
			if (broken) begin
				f = 1'($urandom_range(0, 1));
				l = 1'($urandom_range(0, 1));
			end
			send_plain(mk_req(ipcp_pkg::MODE_REQ, t, pick_value(slot), f, l));
		end
	endtask

	task automatic send_control();
		int k;
		k = $urandom_range(0, 99);
		if (k < 30)
			;
		else if (k < 45)
			send_plain(mk_req(ipcp_pkg::MODE_ACKRX, 8'($urandom()), $urandom(),
				1'($urandom()), 1'($urandom())));
		else if (k < 55)
			send_plain(mk_req(ipcp_pkg::MODE_EMPTY, 8'($urandom()), $urandom(),
				1'($urandom()), 1'($urandom())));
		else if (k < 65)
			send_plain(mk_req(ipcp_pkg::MODE_RESTART, 8'($urandom()), $urandom(),
				1'($urandom()), 1'($urandom())));
		else if (k < 67)
			send_plain(mk_req(ipcp_pkg::MODE_REJOPT,
				KNOWN_TYPES[$urandom_range(0, ipcp_pkg::NUM_OPTS - 1)],
				$urandom(), 1'($urandom()), 1'($urandom())));
		else if (k < 72)
			send_plain(mk_req(ipcp_pkg::MODE_REJOPT, 8'($urandom()), $urandom(),
				1'($urandom()), 1'($urandom())));
		else
			send_plain(mk_req(3'($urandom_range(0, 7)), 8'($urandom()), $urandom(),
				1'($urandom()), 1'($urandom())));
	endtask

	// receiver: random stalls, quiet stretches, and one long hold-off
	initial begin
		int gap;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = receiver_calm ? 0 : $urandom_range(0, 12);
			if (taken == HOLD_AT_RESULT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if ($urandom_range(0, 49) == 0)
				receiver_calm = !receiver_calm;
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("ipcp_option_negotiator: mismatch");
		$finish;
	end

	initial begin
		int start_count;
		mismatches = 0;
		requests_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		reset_shadow();
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(REG_REMOTE, 32'hFFFF_FFFF);
		write_reg(REG_DNS1, 32'h0A00_0001);
		write_reg(REG_DNS2, '0);
		write_reg(REG_NBNS1, '0);
		write_reg(REG_NBNS2, 32'h0000_0001);
		cfg_we <= 1'b0;

		// configured but unset address: nak with zero
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_ADDR, '0, 1'b1, 1'b0), 1'b1,
			mk_res(ipcp_pkg::VERDICT_NAK, '0, ipcp_pkg::VERDICT_NAK, 5'h1F, 1'b0, 1'b0));
		// zero value with nothing configured: reject
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_DNS2, '0, 1'b0, 1'b0), 1'b1,
			mk_res(ipcp_pkg::VERDICT_REJ, '0, ipcp_pkg::VERDICT_REJ, 5'h1F, 1'b0, 1'b0));
		// unknown type echoes its value; last with reject sends no ack
		add_row(mk_req(ipcp_pkg::MODE_REQ, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1), 1'b1,
			mk_res(ipcp_pkg::VERDICT_REJ, 32'hFFFF_FFFF, ipcp_pkg::VERDICT_REJ, 5'h1F,
				1'b0, 1'b0));
		add_row(mk_req(ipcp_pkg::MODE_RESTART, 8'h00, '0, 1'b0, 1'b0), 1'b1,
			mk_res(ipcp_pkg::VERDICT_NONE, '0, ipcp_pkg::VERDICT_REJ, 5'h1F, 1'b0, 1'b0));
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_ADDR, 32'hFFFF_FFFF, 1'b1, 1'b1),
			1'b1, mk_res(ipcp_pkg::VERDICT_ACK, 32'hFFFF_FFFF, ipcp_pkg::VERDICT_ACK, 5'h1F,
				1'b1, 1'b0));
		add_row(mk_req(ipcp_pkg::MODE_ACKRX, 8'h00, '0, 1'b0, 1'b0), 1'b1,
			mk_res(ipcp_pkg::VERDICT_NONE, '0, ipcp_pkg::VERDICT_ACK, 5'h1F, 1'b1, 1'b1));
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_DNS1, 32'h0102_0304, 1'b1, 1'b0),
			1'b0, '0);
		// peer-chosen address, then the same option again
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_NBNS1, 32'h0B0B_0B0B, 1'b0, 1'b0),
			1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_NBNS1, 32'h0B0B_0B0B, 1'b0, 1'b0),
			1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_NBNS2, 32'h0000_0001, 1'b0, 1'b1),
			1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_EMPTY, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REJOPT, ipcp_pkg::OPT_DNS2, '0, 1'b0, 1'b0), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REJOPT, 8'h00, '0, 1'b0, 1'b0), 1'b0, '0);
		add_row(mk_req(3'd5, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0);
		add_row(mk_req(3'd6, 8'h55, 32'h5555_5555, 1'b0, 1'b1), 1'b0, '0);
		add_row(mk_req(3'd7, 8'hAA, 32'hAAAA_AAAA, 1'b1, 1'b0), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_DNS2, 32'h1234_5678, 1'b1, 1'b1),
			1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, 8'd128, '0, 1'b1, 1'b0), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, 8'd133, 32'h8000_0000, 1'b0, 1'b1), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_DNS1, 32'h0A00_0001, 1'b1, 1'b1),
			1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_RESTART, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, '0);
		add_row(mk_req(ipcp_pkg::MODE_REQ, ipcp_pkg::OPT_DNS2, 32'h1234_5678, 1'b1, 1'b1),
			1'b0, '0);

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			for (int r = 0; r < NUM_REGS; r++)
				write_reg(r[ipcp_pkg::CFG_IDX_W-1:0], pick_addr(p % 5, r));
			if (p % 3 == 0)
				write_reg(3'($urandom_range(NUM_REGS, 7)), $urandom());
			cfg_we <= 1'b0;
			if ($urandom_range(0, 1) == 1)
				send_plain(mk_req(ipcp_pkg::MODE_RESTART, 8'($urandom()), $urandom(),
					1'($urandom()), 1'($urandom())));
			start_count = requests_sent;
			while (requests_sent - start_count < PHASE_ITEMS) begin
				send_packet();
				send_control();
				if ($urandom_range(0, 7) == 0)
					sender_calm = !sender_calm;
			end
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d register settings, %0d register writes",
			requests_sent, RANDOM_PHASES + 1, reg_writes);
		$display("%0d results checked, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("ipcp_option_negotiator: match");
		else
			$display("ipcp_option_negotiator: mismatch");
		$finish;
	end

endmodule
